>>> rtl/core/clipped_box_blur_rgb_defines.svh
// Assertion macros shared by the box blur RTL.
`ifndef CLIPPED_BOX_BLUR_RGB_DEFINES_SVH
`define CLIPPED_BOX_BLUR_RGB_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CBB_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("cbb assertion failed");

// Check that a condition implies another in the next cycle.
`define CBB_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("cbb assertion failed");

`endif

>>> rtl/core/cbb_pkg.sv
// Shared types and constants of the clipped box blur.
`timescale 1ns / 1ps
package cbb_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int RADIUS_W     = 4;
    localparam int WIDTH_W      = 12;
    localparam int HEIGHT_W     = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = CFG_INDEX_W'(2);

    // Register values after reset
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    typedef struct packed {
        logic                    flush;
        logic [CHANNEL_BITS-1:0] in_red;
        logic [CHANNEL_BITS-1:0] in_green;
        logic [CHANNEL_BITS-1:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_red;
        logic [CHANNEL_BITS-1:0] out_green;
        logic [CHANNEL_BITS-1:0] out_blue;
        logic                    row_end;
        logic                    frame_end;
    } pix_out_t;

endpackage

>>> rtl/core/cbb_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/cbb_div.sv
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module cbb_div #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 9
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [2:0][DIVIDEND_W-1:0]               dividend,
    input  logic [DIVISOR_W-1:0]                     divisor,
    output logic                                     done,
    output logic [2:0][cbb_pkg::CHANNEL_BITS-1:0]    quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [DIVISOR_W-1:0]           dsr_reg;
    logic [2:0][DIVISOR_W-1:0]      rem_reg;
    logic [2:0][DIVIDEND_W-1:0]     quo_reg;
    logic [2:0][DIVISOR_W-1:0]      rem_next;
    logic [2:0][DIVIDEND_W-1:0]     quo_next;

    // Shift in one dividend bit, subtract where it fits
    always_comb
    begin
        logic [DIVISOR_W:0] trial;
        logic               fits;
        for (int ch = 0; ch < 3; ch++)
        begin
            trial = {rem_reg[ch], quo_reg[ch][DIVIDEND_W-1]};
            fits  = trial >= {1'b0, dsr_reg};
            rem_next[ch] = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg})
                                : DIVISOR_W'(trial);
            quo_next[ch] = {quo_reg[ch][DIVIDEND_W-2:0], fits};
        end
    end

    // Step the lanes while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            quotient[ch] = quo_reg[ch][cbb_pkg::CHANNEL_BITS-1:0];
        end
    end

endmodule

>>> rtl/core/clipped_box_blur_rgb.sv
// Clipped RGB box blur: row running sums, line store of row sums, window mean per pixel.
// Pixel beat: the pixel state; the last pixel of a row then walks the tail state to write the row tail.
// Result beat: setup, one line store read per window row, the bit-serial divider, then output;
// the reads go one after another through the single read port of the line store.
// Result p leaves after the pixel radius rows and radius pixels later; flush beats drain the end.
// Reset: radius 2, 640x480, counters clear; line store is not cleared and needs no clearing.
`timescale 1ns / 1ps
`include "clipped_box_blur_rgb_defines.svh"
module clipped_box_blur_rgb #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  cbb_pkg::pix_in_t                    pixel,
    output logic                                result_valid,
    input  logic                                result_stall,
    output cbb_pkg::pix_out_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cbb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CB     = cbb_pkg::CHANNEL_BITS;
    localparam int LINES  = 2 * MAX_RADIUS + 1;
    localparam int SW     = $clog2(LINES);
    localparam int TW     = $clog2(2 * LINES);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int RXW    = (RW > cbb_pkg::RADIUS_W) ? RW : cbb_pkg::RADIUS_W;
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int WXW    = (EW > cbb_pkg::WIDTH_W) ? EW : cbb_pkg::WIDTH_W;
    localparam int CLW    = $clog2(MAX_WIDTH);
    localparam int VW0    = $clog2(MAX_WIDTH + MAX_RADIUS);
    localparam int VW     = (VW0 > RW + 1) ? VW0 : RW + 1;
    localparam int HW     = cbb_pkg::HEIGHT_W;
    localparam int NW     = $clog2(LINES + 1);
    localparam int CNT_W  = $clog2(LINES * LINES + 1);
    localparam int HSUM_W = CB + $clog2(LINES + 1);
    localparam int VSUM_W = HSUM_W + $clog2(LINES + 1);
    localparam int DEPTH  = LINES * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int MW     = 3 * HSUM_W;
    localparam int LW     = HW + EW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIX,
        S_TAIL,
        S_SETUP,
        S_READ,
        S_DIV,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [cbb_pkg::RADIUS_W-1:0]    radius_reg;
    logic [cbb_pkg::WIDTH_W-1:0]     width_reg;
    logic [cbb_pkg::HEIGHT_W-1:0]    height_reg;
    cbb_pkg::pix_in_t                in_reg;
    logic [VW-1:0]                   col_reg;
    logic [SW-1:0]                   col_mod_reg;
    logic [HW-1:0]                   in_row_reg;
    logic [SW-1:0]                   in_slot_reg;
    logic                            done_reg;
    logic                            emit_reg;
    logic [2:0][HSUM_W-1:0]          sum_reg;
    logic [2:0][CB-1:0]              delay_reg [LINES];
    logic [CLW-1:0]                  out_col_reg;
    logic [HW-1:0]                   out_row_reg;
    logic [SW-1:0]                   out_slot_reg;
    logic [SW-1:0]                   rd_slot_reg;
    logic [NW-1:0]                   rd_left_reg;
    logic                            rd_pend_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [2:0][VSUM_W-1:0]          acc_reg;
    logic                            result_valid_reg;
    cbb_pkg::pix_out_t               result_reg;

    // Effective configuration
    logic [RXW-1:0] radius_ext;
    logic [WXW-1:0] width_ext;
    logic [RW-1:0]  r_eff;
    logic [EW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;

    assign radius_ext = RXW'(radius_reg);
    assign width_ext  = WXW'(width_reg);
    assign r_eff = (radius_ext > RXW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_ext);
    assign w_eff = (width_ext == '0) ? EW'(1)
                 : (width_ext > WXW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_ext);
    assign h_eff = (height_reg == '0) ? HW'(1) : height_reg;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(LINES - 1)) ? '0 : s + SW'(1);
    endfunction

    function automatic logic [AW-1:0] line_addr(input logic [SW-1:0] s,
                                                 input logic [CLW-1:0] c);
        return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
    endfunction

    // Handshakes
    logic pixel_accept;
    logic cfg_hit;
    logic out_free;

    assign pixel_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign pixel_accept = pixel_valid && !pixel_stall;
    assign cfg_hit      = cfg_valid && cfg_ready &&
                          (cfg_index == cbb_pkg::REG_RADIUS ||
                           cfg_index == cbb_pkg::REG_WIDTH ||
                           cfg_index == cbb_pkg::REG_HEIGHT);
    assign out_free     = !result_valid_reg || !result_stall;

    // Row running sum: drop the pixel leaving the window, add the new one
    logic [RW:0]            two_r1;
    logic                   drop_en;
    logic [TW-1:0]          drop_tmp;
    logic [SW-1:0]          drop_idx;
    logic [2:0][CB-1:0]     pix_v;
    logic [2:0][HSUM_W-1:0] sum_new;
    logic                   store_en;
    logic [VW-1:0]          end_col;
    logic                   row_last;
    logic                   col_is_wlast;
    logic                   row_is_last;
    logic [LW-1:0]          in_lin;
    logic [LW-1:0]          emit_lead;
    logic                   emit_now;
    logic                   emit_sel;

    assign two_r1   = {r_eff, 1'b1};
    assign drop_en  = col_reg >= VW'(two_r1);
    assign drop_tmp = TW'(col_mod_reg) + TW'(LINES) - TW'(two_r1);
    assign drop_idx = (drop_tmp >= TW'(LINES)) ? SW'(drop_tmp - TW'(LINES)) : SW'(drop_tmp);
    assign store_en = col_reg >= VW'(r_eff);
    assign end_col  = VW'(w_eff) + VW'(r_eff) - VW'(1);
    assign row_last = col_reg == end_col;
    assign col_is_wlast = col_reg == VW'(w_eff) - VW'(1);
    assign row_is_last  = (HW + 1)'(in_row_reg) + (HW + 1)'(1) >= (HW + 1)'(h_eff);
    // Emit once the input is radius rows and radius pixels past the next output
    assign in_lin    = LW'(in_row_reg) * LW'(w_eff) + LW'(col_reg);
    assign emit_lead = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
    assign emit_now  = in_lin >= emit_lead;
    assign emit_sel  = (state_reg == S_PIX) ? emit_now : emit_reg;

    always_comb
    begin
        pix_v[0] = (state_reg == S_PIX) ? in_reg.in_red   : '0;
        pix_v[1] = (state_reg == S_PIX) ? in_reg.in_green : '0;
        pix_v[2] = (state_reg == S_PIX) ? in_reg.in_blue  : '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_new[ch] = sum_reg[ch]
                        - (drop_en ? HSUM_W'(delay_reg[drop_idx][ch]) : HSUM_W'(0))
                        + HSUM_W'(pix_v[ch]);
        end
    end

    // Line store of horizontal sums
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [MW-1:0]   ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [MW-1:0]   ram_rdata;

    assign ram_we    = (state_reg == S_PIX || state_reg == S_TAIL) && store_en;
    assign ram_waddr = line_addr(in_slot_reg, CLW'(col_reg - VW'(r_eff)));
    assign ram_wdata = {sum_new[2], sum_new[1], sum_new[0]};
    assign ram_re    = (state_reg == S_READ) && (rd_left_reg != '0);
    assign ram_raddr = line_addr(rd_slot_reg, out_col_reg);

    cbb_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clipped window of the next result
    logic [HW:0]     rowx, r0, r1;
    logic [VW:0]     colx, c0, c1;
    logic [NW-1:0]   nrows, ncols;
    logic [TW-1:0]   st_tmp;
    logic [SW-1:0]   st_slot;
    logic [CNT_W-1:0] count;
    logic            row_end_now;
    logic            frame_end_now;

    always_comb
    begin
        rowx = (HW + 1)'(out_row_reg);
        r0 = (rowx >= (HW + 1)'(r_eff)) ? rowx - (HW + 1)'(r_eff) : '0;
        r1 = (rowx + (HW + 1)'(r_eff) > (HW + 1)'(h_eff) - (HW + 1)'(1))
           ? (HW + 1)'(h_eff) - (HW + 1)'(1) : rowx + (HW + 1)'(r_eff);
        colx = (VW + 1)'(out_col_reg);
        c0 = (colx >= (VW + 1)'(r_eff)) ? colx - (VW + 1)'(r_eff) : '0;
        c1 = (colx + (VW + 1)'(r_eff) > (VW + 1)'(w_eff) - (VW + 1)'(1))
           ? (VW + 1)'(w_eff) - (VW + 1)'(1) : colx + (VW + 1)'(r_eff);
        nrows = NW'(r1 - r0 + (HW + 1)'(1));
        ncols = NW'(c1 - c0 + (VW + 1)'(1));
        st_tmp = TW'(out_slot_reg) + TW'(LINES) - TW'(rowx - r0);
        st_slot = (st_tmp >= TW'(LINES)) ? SW'(st_tmp - TW'(LINES)) : SW'(st_tmp);
        count = CNT_W'(ncols) * CNT_W'(nrows);
    end

    assign row_end_now   = VW'(out_col_reg) == VW'(w_eff) - VW'(1);
    assign frame_end_now = row_end_now && (out_row_reg == h_eff - HW'(1));

    // Window mean
    logic               div_start;
    logic               div_done;
    logic [2:0][CB-1:0] div_q;

    assign div_start = (state_reg == S_READ) && (rd_left_reg == '0) && !rd_pend_reg;

    cbb_div #(
        .DIVIDEND_W (VSUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    logic restart;
    assign restart = cfg_hit || ((state_reg == S_OUT) && out_free && frame_end_now);

    // Sequencer, counters and row sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            radius_reg       <= cbb_pkg::RADIUS_RESET;
            width_reg        <= cbb_pkg::WIDTH_RESET;
            height_reg       <= cbb_pkg::HEIGHT_RESET;
            col_reg          <= '0;
            col_mod_reg      <= '0;
            in_row_reg       <= '0;
            in_slot_reg      <= '0;
            done_reg         <= 1'b0;
            emit_reg         <= 1'b0;
            sum_reg          <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_slot_reg     <= '0;
            rd_slot_reg      <= '0;
            rd_left_reg      <= '0;
            rd_pend_reg      <= 1'b0;
            cnt_reg          <= '0;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the output beat once taken
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pixel_accept)
                    begin
                        if (done_reg)
                        begin
                            state_reg <= S_SETUP;
                        end
                        else if (!pixel.flush)
                        begin
                            state_reg <= S_PIX;
                        end
                    end
                end
                S_PIX, S_TAIL:
                begin
                    if (state_reg == S_PIX)
                    begin
                        emit_reg <= emit_now;
                    end
                    if (row_last)
                    begin
                        // Close the row
                        sum_reg     <= '0;
                        col_reg     <= '0;
                        col_mod_reg <= '0;
                        if (row_is_last)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            in_row_reg  <= in_row_reg + HW'(1);
                            in_slot_reg <= slot_inc(in_slot_reg);
                        end
                        state_reg <= emit_sel ? S_SETUP : S_IDLE;
                    end
                    else
                    begin
                        sum_reg     <= sum_new;
                        col_reg     <= col_reg + VW'(1);
                        col_mod_reg <= slot_inc(col_mod_reg);
                        if (state_reg == S_TAIL || col_is_wlast)
                        begin
                            state_reg <= S_TAIL;
                        end
                        else
                        begin
                            state_reg <= emit_sel ? S_SETUP : S_IDLE;
                        end
                    end
                end
                S_SETUP:
                begin
                    rd_slot_reg <= st_slot;
                    rd_left_reg <= nrows;
                    rd_pend_reg <= 1'b0;
                    cnt_reg     <= count;
                    acc_reg     <= '0;
                    state_reg   <= S_READ;
                end
                S_READ:
                begin
                    // Issue one line read a cycle, accumulate its data in the next cycle
                    rd_pend_reg <= ram_re;
                    if (ram_re)
                    begin
                        rd_slot_reg <= slot_inc(rd_slot_reg);
                        rd_left_reg <= rd_left_reg - NW'(1);
                    end
                    if (rd_pend_reg)
                    begin
                        for (int ch = 0; ch < 3; ch++)
                        begin
                            acc_reg[ch] <= acc_reg[ch]
                                         + VSUM_W'(ram_rdata[ch*HSUM_W +: HSUM_W]);
                        end
                    end
                    if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        if (row_end_now)
                        begin
                            out_col_reg  <= '0;
                            out_row_reg  <= out_row_reg + HW'(1);
                            out_slot_reg <= slot_inc(out_slot_reg);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + CLW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Start a new frame
            if (restart)
            begin
                col_reg      <= '0;
                col_mod_reg  <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                done_reg     <= 1'b0;
                sum_reg      <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
            end

            // Configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cbb_pkg::REG_RADIUS:
                    begin
                        radius_reg <= cfg_data[cbb_pkg::RADIUS_W-1:0];
                    end
                    cbb_pkg::REG_WIDTH:
                    begin
                        width_reg <= cfg_data[cbb_pkg::WIDTH_W-1:0];
                    end
                    cbb_pkg::REG_HEIGHT:
                    begin
                        height_reg <= cfg_data[cbb_pkg::HEIGHT_W-1:0];
                    end
                    default:
                    begin
                        radius_reg <= radius_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers: input beat, row pixel line, output beat
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            in_reg <= pixel;
        end
        if (state_reg == S_PIX)
        begin
            delay_reg[col_mod_reg] <= {in_reg.in_blue, in_reg.in_green, in_reg.in_red};
        end
        if (state_reg == S_OUT && out_free)
        begin
            result_reg.out_red   <= div_q[0];
            result_reg.out_green <= div_q[1];
            result_reg.out_blue  <= div_q[2];
            result_reg.row_end   <= row_end_now;
            result_reg.frame_end <= frame_end_now;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `CBB_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, ram_we, !ram_re)
    `CBB_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_done, state_reg == S_DIV)
    `CBB_ASSERT_NEXT(a_pixel_starts_work, clk, rst_n, pixel_accept && !pixel.flush, state_reg != S_IDLE)
    `CBB_ASSERT_IMPL(a_done_row_clear, clk, rst_n, done_reg, col_reg == '0 && sum_reg == '0)
    `CBB_ASSERT_IMPL(a_read_bound, clk, rst_n, state_reg == S_READ, rd_left_reg <= NW'(LINES))

endmodule

>>> verif/clipped_box_blur_rgb_checker.sv
// Scoreboard for the clipped box blur: predicts every result beat and compares it.
`timescale 1ns / 1ps
module clipped_box_blur_rgb_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    input  logic                            pixel_stall,
    input  cbb_pkg::pix_in_t                pixel,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  cbb_pkg::pix_out_t               result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cbb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              result_count
);

    localparam int MAX_R = 8;
    localparam int MAX_W = 2048;
    localparam int LINES = 2 * MAX_R + 1;

    // Register copies
    logic [cbb_pkg::RADIUS_W-1:0] radius_q;
    logic [cbb_pkg::WIDTH_W-1:0]  width_q;
    logic [cbb_pkg::HEIGHT_W-1:0] height_q;

    // Filter state
    int unsigned row_sum [3];
    int unsigned tap_line [LINES][3];
    int unsigned hsum_red [LINES*MAX_W];
    int unsigned hsum_green [LINES*MAX_W];
    int unsigned hsum_blue [LINES*MAX_W];
    int unsigned col_in, row_in, out_pos;
    bit          frame_in_done;

    cbb_pkg::pix_out_t blurred_q [$];

    function automatic int unsigned eff_radius();
        return (radius_q > MAX_R) ? MAX_R : radius_q;
    endfunction

    function automatic int unsigned eff_width();
        if (width_q == 0)
            return 1;
        return (width_q > MAX_W) ? MAX_W : width_q;
    endfunction

    function automatic int unsigned eff_height();
        return (height_q == 0) ? 1 : height_q;
    endfunction

    task automatic restart_frame();
        col_in = 0;
        row_in = 0;
        out_pos = 0;
        frame_in_done = 0;
        for (int c = 0; c < 3; c++)
            row_sum[c] = 0;
    endtask

    task automatic store_row_sum(input int unsigned col);
        int unsigned base;
        base = (row_in % LINES) * MAX_W + col;
        hsum_red[base] = row_sum[0];
        hsum_green[base] = row_sum[1];
        hsum_blue[base] = row_sum[2];
    endtask

    task automatic retire_tap(input int unsigned col);
        for (int c = 0; c < 3; c++)
            row_sum[c] -= tap_line[col % LINES][c];
    endtask

    // Compute the clipped window mean at the current output position
    task automatic push_window_mean();
        int unsigned rr, ww, hh, r, c, r0, r1, c0, c1, base;
        longint unsigned cnt, s_r, s_g, s_b;
        cbb_pkg::pix_out_t o;
        rr = eff_radius();
        ww = eff_width();
        hh = eff_height();
        r = out_pos / ww;
        c = out_pos % ww;
        r0 = (r >= rr) ? r - rr : 0;
        r1 = (r + rr > hh - 1) ? hh - 1 : r + rr;
        c0 = (c >= rr) ? c - rr : 0;
        c1 = (c + rr > ww - 1) ? ww - 1 : c + rr;
        cnt = longint'(c1 - c0 + 1) * longint'(r1 - r0 + 1);
        s_r = 0;
        s_g = 0;
        s_b = 0;
        for (int unsigned y = r0; y <= r1; y++)
        begin
            base = (y % LINES) * MAX_W + c;
            s_r += hsum_red[base];
            s_g += hsum_green[base];
            s_b += hsum_blue[base];
        end
        o.out_red = 16'(s_r / cnt);
        o.out_green = 16'(s_g / cnt);
        o.out_blue = 16'(s_b / cnt);
        o.row_end = (c == ww - 1);
        o.frame_end = (out_pos == ww * hh - 1);
        blurred_q.push_back(o);
        if (o.frame_end)
            restart_frame();
        else
            out_pos++;
    endtask

    // Advance the filter by one accepted input beat
    task automatic take_pixel(input cbb_pkg::pix_in_t px);
        int unsigned rr, ww, hh, k, idx, lo_cur, lo, j;
        int unsigned v [3];
        rr = eff_radius();
        ww = eff_width();
        hh = eff_height();
        if (frame_in_done)
        begin
            push_window_mean();
            return;
        end
        if (px.flush)
            return;
        v[0] = px.in_red;
        v[1] = px.in_green;
        v[2] = px.in_blue;
        k = col_in;
        idx = row_in * ww + k;
        if (k >= 2 * rr + 1)
            retire_tap(k - 2 * rr - 1);
        for (int c = 0; c < 3; c++)
        begin
            row_sum[c] += v[c];
            tap_line[k % LINES][c] = v[c];
        end
        if (k >= rr)
            store_row_sum(k - rr);
        if (k == ww - 1)
        begin
            // Finish the row tail with the shrinking window
            lo_cur = (k >= 2 * rr) ? k - 2 * rr : 0;
            j = (ww > rr) ? ww - rr : 0;
            for (; j < ww; j++)
            begin
                lo = (j >= rr) ? j - rr : 0;
                while (lo_cur < lo)
                begin
                    retire_tap(lo_cur);
                    lo_cur++;
                end
                store_row_sum(j);
            end
            for (int c = 0; c < 3; c++)
                row_sum[c] = 0;
            col_in = 0;
            if (row_in + 1 >= hh)
                frame_in_done = 1;
            else
                row_in++;
        end
        else
        begin
            col_in++;
        end
        if (idx >= rr * ww + rr)
            push_window_mean();
    endtask

    task automatic compare_beat(input cbb_pkg::pix_out_t got);
        cbb_pkg::pix_out_t want;
        result_count++;
        if (blurred_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: unexpected result beat %p", got);
            return;
        end
        want = blurred_q.pop_front();
        if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
            got.out_blue !== want.out_blue || got.row_end !== want.row_end ||
            got.frame_end !== want.frame_end)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: result %0d expected %p got %p", result_count, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_q = cbb_pkg::RADIUS_RESET;
            width_q = cbb_pkg::WIDTH_RESET;
            height_q = cbb_pkg::HEIGHT_RESET;
            for (int t = 0; t < LINES; t++)
                for (int c = 0; c < 3; c++)
                    tap_line[t][c] = 0;
            restart_frame();
            blurred_q.delete();
            fail_count = 0;
            result_count = 0;
            pending = 0;
        end
        else
        begin
            // Check outgoing beat first, then apply register write and input beat
            if (result_valid && !result_stall)
                compare_beat(result);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cbb_pkg::REG_RADIUS: radius_q = cfg_data[cbb_pkg::RADIUS_W-1:0];
                    cbb_pkg::REG_WIDTH:  width_q = cfg_data[cbb_pkg::WIDTH_W-1:0];
                    cbb_pkg::REG_HEIGHT: height_q = cfg_data[cbb_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
                if (cfg_index == cbb_pkg::REG_RADIUS || cfg_index == cbb_pkg::REG_WIDTH ||
                    cfg_index == cbb_pkg::REG_HEIGHT)
                begin
                    restart_frame();
                    blurred_q.delete();
                end
            end
            if (pixel_valid && !pixel_stall)
                take_pixel(pixel);
            pending = blurred_q.size();
        end
    end

    // Report leftovers at end of run through the pending count
endmodule

>>> verif/clipped_box_blur_rgb_test.sv
// Top of the box blur testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module clipped_box_blur_rgb_test;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 60;

    logic                            clk;
    logic                            rst_n;
    logic                            pixel_valid;
    logic                            pixel_stall;
    cbb_pkg::pix_in_t                pixel;
    logic                            result_valid;
    logic                            result_stall;
    cbb_pkg::pix_out_t               result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [cbb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cbb_pkg::CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count;
    int item_count;
    int frame_count;
    int cfg_count;
    bit quiet;
    bit hold_req;

    int unsigned cur_radius;
    int unsigned cur_width;
    int unsigned cur_height;

    clipped_box_blur_rgb dut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    clipped_box_blur_rgb_checker scoreboard (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending),
        .result_count(result_count)
    );

    initial
    begin
        clk = 0;
    end

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stall per beat, one long hold-off on request
    initial
    begin
        int n;
        result_stall = 0;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_stall = 1;
                repeat (300) @(negedge clk);
                hold_req = 0;
            end
            n = quiet ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                result_stall = 1;
                repeat (n) @(negedge clk);
            end
            result_stall = 0;
            do
                @(posedge clk);
            while (!result_valid && !hold_req);
            @(negedge clk);
        end
    end

    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cbb_pkg::pix_in_t random_pixel(input logic fl);
        cbb_pkg::pix_in_t px;
        px.flush = fl;
        px.in_red = pick_channel();
        px.in_green = pick_channel();
        px.in_blue = pick_channel();
        return px;
    endfunction

    // Send one input beat; called and returns at a falling edge
    task automatic send_beat(input cbb_pkg::pix_in_t px);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            pixel_valid = 0;
            repeat (gap) @(negedge clk);
        end
        pixel = px;
        pixel_valid = 1;
        do
            @(posedge clk);
        while (pixel_stall);
        @(negedge clk);
        item_count++;
    endtask

    task automatic write_reg(input logic [cbb_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned val);
        cfg_index = idx;
        cfg_data = cbb_pkg::CFG_DATA_W'(val);
        cfg_valid = 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
        cfg_count++;
    endtask

    // Idle the input, drain all results and let the block settle
    task automatic drain();
        pixel_valid = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input int unsigned r, input int unsigned w, input int unsigned h);
        int order;
        drain();
        cur_radius = r;
        cur_width = w;
        cur_height = h;
        order = $urandom_range(0, 1);
        if (order)
            write_reg(cbb_pkg::REG_HEIGHT, h);
        write_reg(cbb_pkg::REG_RADIUS, r);
        write_reg(cbb_pkg::REG_WIDTH, w);
        if (!order)
            write_reg(cbb_pkg::REG_HEIGHT, h);
    endtask

    // One whole frame: pixels, stray flushes mid-frame if asked, then the drain beats
    task automatic run_frame(input bit stray);
        int unsigned rr, ww, hh, total, lead, tail;
        rr = (cur_radius > 8) ? 8 : cur_radius;
        ww = (cur_width == 0) ? 1 : ((cur_width > 2048) ? 2048 : cur_width);
        hh = (cur_height == 0) ? 1 : cur_height;
        total = ww * hh;
        lead = rr * ww + rr;
        tail = (total > lead) ? lead : total;
        for (int unsigned p = 0; p < total; p++)
        begin
            if (stray && $urandom_range(0, 15) == 0)
                send_beat(random_pixel(1));
            send_beat(random_pixel(0));
        end
        // A pixel after the last row is dropped and drains like a flush
        for (int unsigned f = 0; f < tail; f++)
            send_beat(random_pixel($urandom_range(0, 3) != 0));
        frame_count++;
    endtask

    initial
    begin
        int unsigned r, w, h;
        rst_n = 0;
        pixel_valid = 0;
        pixel = '0;
        cfg_valid = 0;
        cfg_index = cbb_pkg::REG_RADIUS;
        cfg_data = '0;
        quiet = 0;
        hold_req = 0;
        item_count = 0;
        frame_count = 0;
        cfg_count = 0;
        cycle_count = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: stray flush, then a small frame of extreme values
        configure(2, 5, 3);
        send_beat(random_pixel(1));
        for (int p = 0; p < 15; p++)
        begin
            cbb_pkg::pix_in_t px;
            px.flush = 0;
            px.in_red = (p % 2) ? 16'hFFFF : 16'h0000;
            px.in_green = (p % 3) ? 16'h0000 : 16'hFFFF;
            px.in_blue = 16'hFFFF;
            send_beat(px);
        end
        for (int f = 0; f < 12; f++)
            send_beat(random_pixel(1));
        frame_count++;
        // Radius zero passes through; saturating radius; zero width and height
        configure(0, 3, 2);
        run_frame(0);
        configure(15, 4, 3);
        run_frame(0);
        configure(1, 0, 0);
        run_frame(0);
        configure(8, 1, 20);
        run_frame(0);
        // Back-to-back frames with no register write between them
        configure(1, 3, 3);
        run_frame(0);
        run_frame(0);

        // Fill the block against a long result hold-off
        configure(3, 12, 6);
        hold_req = 1;
        run_frame(1);

        // Random frames, mostly small
        while (item_count < 1000)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 24);
            h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 10);
            configure(r, w, h);
            run_frame(1);
            if ($urandom_range(0, 3) == 0)
                run_frame(1);
        end
        quiet = 0;

        drain();
        $display("Covered %0d frames, %0d input beats, %0d result beats, %0d register writes",
                 frame_count, item_count, result_count, cfg_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
